// ===== design/quaternion_arithmetic_unit_top_defines.svh =====
// Assertion macros for the quaternion unit checker.
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qau_pkg.sv =====
`timescale 1ns / 1ps
package qau_pkg;

    // fractional bits of the Q format
    localparam int FRAC_BITS = 16;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_MUL   = 4'd2;
    localparam logic [3:0] CMD_SCALE = 4'd3;
    localparam logic [3:0] CMD_CONJ  = 4'd4;
    localparam logic [3:0] CMD_NORM  = 4'd5;
    localparam logic [3:0] CMD_NRMZ  = 4'd6;
    localparam logic [3:0] CMD_INV   = 4'd7;
    localparam logic [3:0] CMD_MAT   = 4'd8;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
        logic signed [31:0] scale_val;
    } op_t;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_w;
        logic               last;
        logic [1:0]         status;
    } res_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic [1:0]         status;
    } row_t;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        r.flag = 1'b0;
        r.val  = v[31:0];
        if (v > 66'sd2147483647)
        begin
            r.flag = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            r.flag = 1'b1;
            r.val  = 32'sh8000_0000;
        end
        return r;
    endfunction

    function automatic row_t mk_row(input logic signed [65:0] x, input logic signed [65:0] y,
                                    input logic signed [65:0] z, input logic signed [65:0] w,
                                    input logic [1:0] st);
        sat_t sx;
        sat_t sy;
        sat_t sz;
        sat_t sw;
        row_t r;
        sx = sat32(x);
        sy = sat32(y);
        sz = sat32(z);
        sw = sat32(w);
        r.x = sx.val;
        r.y = sy.val;
        r.z = sz.val;
        r.w = sw.val;
        r.status = (st == STAT_OK && (sx.flag || sy.flag || sz.flag || sw.flag))
                   ? STAT_SAT : st;
        return r;
    endfunction

endpackage

// ===== design/quaternion_arithmetic_unit_top.sv =====
// channel | role     | payload        | handshake
// op      | command  | qau_pkg::op_t  | op_valid / op_ready
// res     | result   | qau_pkg::res_t | res_valid / res_ready
//
// Five register stages: multiply, sum, shift/saturate, iterate, output.
// Add, sub, mul, scale, conj: one item per cycle unless res_ready or stage 4 stalls.
// Matrix: three back-to-back row transfers while res_ready is high; later items wait.
// Norm: the shared root/divide stage finds 32 root bits, then one finish step;
// normalize adds 32+FRAC_BITS divide steps to that, inverse takes 32+2*FRAC_BITS
// divide steps plus the finish step; later items wait behind them.
// Reset clears valid bits and stage-4/output control only; a stall holds full stages.
`timescale 1ns / 1ps
module quaternion_arithmetic_unit_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  qau_pkg::op_t  op_data,
    output logic          res_valid,
    input  logic          res_ready,
    output qau_pkg::res_t res_data
);
    import qau_pkg::*;

    localparam int F1        = FRAC_BITS - 1;
    localparam int SQRT_ITER = 32;
    localparam int NRM_ITER  = 32 + FRAC_BITS;
    localparam int INV_ITER  = 32 + 2 * FRAC_BITS;
    localparam int CNT_W     = $clog2(INV_ITER);
    localparam logic signed [65:0] ONE_W = 66'sd1 <<< FRAC_BITS;
    localparam logic [33:0] Q_CAP = 34'h1_0000_0000;

    // stage-4 phases
    localparam logic [1:0] PH_DONE = 2'd0;
    localparam logic [1:0] PH_SQRT = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    // per-stage ready: the stage is empty or hands its item on this cycle
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic done4, last5;

    // ---------------- stage 1: 16 parallel 32x32 products ----------------
    logic                v1_reg;
    logic [3:0]          cmd1_reg;
    logic signed [31:0]  a1_reg [4];
    logic signed [31:0]  b1_reg [4];
    logic signed [63:0]  p1_reg [4][4];
    logic signed [31:0]  a_in [4];
    logic signed [31:0]  b_in [4];
    logic signed [31:0]  bm [4];
    logic signed [63:0]  p_next [4][4];

    always_comb
    begin
        a_in[0] = op_data.a_x;
        a_in[1] = op_data.a_y;
        a_in[2] = op_data.a_z;
        a_in[3] = op_data.a_w;
        b_in[0] = op_data.b_x;
        b_in[1] = op_data.b_y;
        b_in[2] = op_data.b_z;
        b_in[3] = op_data.b_w;
        // mul uses B; scale uses the scalar; everything else squares A
        for (int j = 0; j < 4; j++)
        begin
            if (op_data.cmd == CMD_MUL)
                bm[j] = b_in[j];
            else if (op_data.cmd == CMD_SCALE)
                bm[j] = op_data.scale_val;
            else
                bm[j] = a_in[j];
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p_next[i][j] = a_in[i] * bm[j];
            end
        end
    end

    // ---------------- stage 2: sums of products (exact, 66 bits) ----------------
    logic                v2_reg;
    logic [3:0]          cmd2_reg;
    logic signed [31:0]  a2_reg [4];
    logic signed [65:0]  w2_reg [9];
    logic signed [65:0]  w_next [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            w_next[k] = '0;
        end
        case (cmd1_reg) inside
            CMD_ADD:
                for (int i = 0; i < 4; i++)
                begin
                    w_next[i] = 66'(a1_reg[i]) + 66'(b1_reg[i]);
                end
            CMD_SUB:
                for (int i = 0; i < 4; i++)
                begin
                    w_next[i] = 66'(a1_reg[i]) - 66'(b1_reg[i]);
                end
            CMD_CONJ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_next[i] = -66'(a1_reg[i]);
                end
                w_next[3] = 66'(a1_reg[3]);
            end
            CMD_MUL:
            begin
                w_next[0] = 66'(p1_reg[3][0]) + 66'(p1_reg[0][3])
                          + 66'(p1_reg[1][2]) - 66'(p1_reg[2][1]);
                w_next[1] = 66'(p1_reg[3][1]) + 66'(p1_reg[1][3])
                          + 66'(p1_reg[2][0]) - 66'(p1_reg[0][2]);
                w_next[2] = 66'(p1_reg[3][2]) + 66'(p1_reg[2][3])
                          + 66'(p1_reg[0][1]) - 66'(p1_reg[1][0]);
                w_next[3] = 66'(p1_reg[3][3]) - 66'(p1_reg[0][0])
                          - 66'(p1_reg[1][1]) - 66'(p1_reg[2][2]);
            end
            CMD_SCALE:
                for (int i = 0; i < 4; i++)
                begin
                    w_next[i] = 66'(p1_reg[i][3]);
                end
            CMD_NORM, CMD_NRMZ, CMD_INV:
                w_next[0] = 66'(p1_reg[0][0]) + 66'(p1_reg[1][1])
                          + 66'(p1_reg[2][2]) + 66'(p1_reg[3][3]);
            CMD_MAT:
            begin
                // B was forced to A, so p[i][j] = a_i * a_j
                w_next[0] = 66'(p1_reg[1][1]) + 66'(p1_reg[2][2]);
                w_next[1] = 66'(p1_reg[0][1]) - 66'(p1_reg[2][3]);
                w_next[2] = 66'(p1_reg[0][2]) + 66'(p1_reg[1][3]);
                w_next[3] = 66'(p1_reg[0][1]) + 66'(p1_reg[2][3]);
                w_next[4] = 66'(p1_reg[0][0]) + 66'(p1_reg[2][2]);
                w_next[5] = 66'(p1_reg[1][2]) - 66'(p1_reg[0][3]);
                w_next[6] = 66'(p1_reg[0][2]) - 66'(p1_reg[1][3]);
                w_next[7] = 66'(p1_reg[1][2]) + 66'(p1_reg[0][3]);
                w_next[8] = 66'(p1_reg[0][0]) + 66'(p1_reg[1][1]);
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- stage 3: shift, saturate, special cases ----------------
    logic                v3_reg;
    row_t                rows3_reg [3];
    logic                mat3_reg;
    logic                long3_reg;
    logic                sqrt3_reg;
    logic                norm3_reg;
    logic [31:0]         mag3_reg [4];
    logic                neg3_reg [4];
    logic [63:0]         sq3_reg;

    row_t                rows_c [3];
    logic                mat_c, long_c, sqrt_c, norm_c;
    logic [31:0]         mag_c [4];
    logic                neg_c [4];
    logic [63:0]         sq_c;

    always_comb
    begin
        // sum of squares clamps at all ones (only when every component is min)
        sq_c = (w2_reg[0][65:64] != 2'b00) ? '1 : w2_reg[0][63:0];
        for (int r = 0; r < 3; r++)
        begin
            rows_c[r] = '0;
        end
        mat_c  = 1'b0;
        long_c = 1'b0;
        sqrt_c = 1'b0;
        norm_c = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mag_c[i] = a2_reg[i][31] ? 32'(-a2_reg[i]) : 32'(a2_reg[i]);
            // inverse negates x, y, z through the conjugate
            neg_c[i] = (cmd2_reg == CMD_INV) ? (a2_reg[i][31] ^ (i < 3)) : a2_reg[i][31];
        end
        case (cmd2_reg) inside
            CMD_ADD, CMD_SUB, CMD_CONJ:
                rows_c[0] = mk_row(w2_reg[0], w2_reg[1], w2_reg[2], w2_reg[3], STAT_OK);
            CMD_MUL, CMD_SCALE:
                rows_c[0] = mk_row(w2_reg[0] >>> FRAC_BITS, w2_reg[1] >>> FRAC_BITS,
                                   w2_reg[2] >>> FRAC_BITS, w2_reg[3] >>> FRAC_BITS,
                                   STAT_OK);
            CMD_MAT:
            begin
                mat_c = 1'b1;
                rows_c[0] = mk_row(ONE_W - (w2_reg[0] >>> F1), w2_reg[1] >>> F1,
                                   w2_reg[2] >>> F1, '0, STAT_OK);
                rows_c[1] = mk_row(w2_reg[3] >>> F1, ONE_W - (w2_reg[4] >>> F1),
                                   w2_reg[5] >>> F1, '0, STAT_OK);
                rows_c[2] = mk_row(w2_reg[6] >>> F1, w2_reg[7] >>> F1,
                                   ONE_W - (w2_reg[8] >>> F1), '0, STAT_OK);
            end
            CMD_NORM:
            begin
                long_c = 1'b1;
                sqrt_c = 1'b1;
                norm_c = 1'b1;
            end
            CMD_NRMZ:
                if (sq_c == '0)
                    rows_c[0] = mk_row(66'(a2_reg[0]), 66'(a2_reg[1]), 66'(a2_reg[2]),
                                       66'(a2_reg[3]), STAT_OK);
                else
                begin
                    long_c = 1'b1;
                    sqrt_c = 1'b1;
                end
            CMD_INV:
                if (sq_c == '0)
                    rows_c[0].status = STAT_ZERO;
                else
                    long_c = 1'b1;
            default:
            begin
            end
        endcase
    end

    // ---------------- stage 4: shared root / divide iterator ----------------
    logic                v4_reg;
    logic [1:0]          ph_reg;
    logic [CNT_W-1:0]    cnt_reg;
    row_t                rows4_reg [3];
    logic                mat4_reg;
    logic                norm4_reg;
    logic                neg4_reg [4];
    logic [31:0]         num_reg [4];
    logic [63:0]         rem_reg [4];
    logic [32:0]         quo_reg [4];
    logic [63:0]         d_reg;
    logic [63:0]         rad_reg;
    logic [33:0]         srem_reg;
    logic [31:0]         root_reg;

    logic [35:0]         remsh, trial;
    logic                sq_ge;
    logic [33:0]         srem_step;
    logic [31:0]         root_step;
    logic [64:0]         rsh [4];
    logic                dv_ge [4];
    logic [63:0]         rem_step [4];
    logic [33:0]         qsh [4];
    logic [32:0]         quo_step [4];
    logic signed [65:0]  sv [4];
    row_t                fin_row;

    always_comb
    begin
        // one root bit per cycle
        remsh     = {srem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        sq_ge     = remsh >= trial;
        srem_step = sq_ge ? 34'(remsh - trial) : remsh[33:0];
        root_step = {root_reg[30:0], sq_ge};
        // one quotient bit per cycle in each lane, quotient clamped at 2^32
        for (int i = 0; i < 4; i++)
        begin
            rsh[i]      = {rem_reg[i], num_reg[i][31]};
            dv_ge[i]    = rsh[i] >= {1'b0, d_reg};
            rem_step[i] = dv_ge[i] ? 64'(rsh[i] - {1'b0, d_reg}) : rsh[i][63:0];
            qsh[i]      = {quo_reg[i], dv_ge[i]};
            quo_step[i] = (qsh[i] > Q_CAP) ? Q_CAP[32:0] : qsh[i][32:0];
            sv[i]       = neg4_reg[i] ? -66'({33'b0, quo_reg[i]}) : 66'({33'b0, quo_reg[i]});
        end
        if (norm4_reg)
            fin_row = mk_row(66'({34'b0, root_reg}), '0, '0, '0, STAT_OK);
        else
            fin_row = mk_row(sv[0], sv[1], sv[2], sv[3], STAT_OK);
    end

    // ---------------- stage 5: output register, matrix rows ----------------
    logic                v5_reg;
    logic [1:0]          idx5_reg;
    row_t                rows5_reg [3];
    logic                mat5_reg;

    assign done4 = v4_reg && ph_reg == PH_DONE;
    assign last5 = !mat5_reg || idx5_reg == 2'd2;
    assign rdy5  = !v5_reg || (res_ready && last5);
    assign rdy4  = !v4_reg || (ph_reg == PH_DONE && rdy5);
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign op_ready = rdy1;

    assign res_valid       = v5_reg;
    assign res_data.res_x  = rows5_reg[idx5_reg].x;
    assign res_data.res_y  = rows5_reg[idx5_reg].y;
    assign res_data.res_z  = rows5_reg[idx5_reg].z;
    assign res_data.res_w  = rows5_reg[idx5_reg].w;
    assign res_data.status = rows5_reg[idx5_reg].status;
    assign res_data.last   = last5;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            ph_reg   <= PH_DONE;
            cnt_reg  <= '0;
            idx5_reg <= '0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= op_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
            begin
                v4_reg <= v3_reg;
                if (v3_reg)
                begin
                    ph_reg  <= long3_reg ? (sqrt3_reg ? PH_SQRT : PH_DIV) : PH_DONE;
                    cnt_reg <= sqrt3_reg ? CNT_W'(SQRT_ITER - 1) : CNT_W'(INV_ITER - 1);
                end
            end
            else
            begin
                unique case (ph_reg)
                    PH_SQRT:
                        if (cnt_reg == '0)
                        begin
                            ph_reg  <= norm4_reg ? PH_FIN : PH_DIV;
                            cnt_reg <= CNT_W'(NRM_ITER - 1);
                        end
                        else
                            cnt_reg <= cnt_reg - 1'b1;
                    PH_DIV:
                        if (cnt_reg == '0)
                            ph_reg <= PH_FIN;
                        else
                            cnt_reg <= cnt_reg - 1'b1;
                    PH_FIN:
                        ph_reg <= PH_DONE;
                    default:
                    begin
                    end
                endcase
            end
            if (rdy5)
            begin
                v5_reg   <= done4;
                idx5_reg <= '0;
            end
            else if (res_ready)
                idx5_reg <= idx5_reg + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (rdy1 && op_valid)
        begin
            cmd1_reg <= op_data.cmd;
            a1_reg   <= a_in;
            b1_reg   <= b_in;
            p1_reg   <= p_next;
        end
        if (rdy2 && v1_reg)
        begin
            cmd2_reg <= cmd1_reg;
            a2_reg   <= a1_reg;
            w2_reg   <= w_next;
        end
        if (rdy3 && v2_reg)
        begin
            rows3_reg <= rows_c;
            mat3_reg  <= mat_c;
            long3_reg <= long_c;
            sqrt3_reg <= sqrt_c;
            norm3_reg <= norm_c;
            mag3_reg  <= mag_c;
            neg3_reg  <= neg_c;
            sq3_reg   <= sq_c;
        end
        if (rdy4 && v3_reg)
        begin
            rows4_reg <= rows3_reg;
            mat4_reg  <= mat3_reg;
            norm4_reg <= norm3_reg;
            neg4_reg  <= neg3_reg;
            num_reg   <= mag3_reg;
            d_reg     <= sq3_reg;
            rad_reg   <= sq3_reg;
            srem_reg  <= '0;
            root_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
        end
        else if (!rdy4)
        begin
            case (ph_reg)
                PH_SQRT:
                begin
                    srem_reg <= srem_step;
                    root_reg <= root_step;
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    // normalize divides by the finished root
                    if (cnt_reg == '0)
                        d_reg <= {32'b0, root_step};
                end
                PH_DIV:
                    for (int i = 0; i < 4; i++)
                    begin
                        rem_reg[i] <= rem_step[i];
                        quo_reg[i] <= quo_step[i];
                        num_reg[i] <= {num_reg[i][30:0], 1'b0};
                    end
                PH_FIN:
                    rows4_reg[0] <= fin_row;
                default:
                begin
                end
            endcase
        end
        if (rdy5 && done4)
        begin
            rows5_reg <= rows4_reg;
            mat5_reg  <= mat4_reg;
        end
    end

endmodule

// ===== design/qau_checker.sv =====
`timescale 1ns / 1ps
`include "quaternion_arithmetic_unit_top_defines.svh"
module qau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input qau_pkg::res_t res_data
);
    import qau_pkg::*;

    // stalled result holds
    `QAU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed under stall")
    // matrix rows follow one another without a gap
    `QAU_ASSERT_NEXT(a_rows_gapless, res_valid && res_ready && !res_data.last, res_valid, "gap between matrix rows")
    // only matrix rows are non-final and they carry w = 0
    `QAU_ASSERT_NOW(a_row_format, res_valid && !res_data.last, res_data.res_w == 32'sd0 && res_data.status != STAT_ZERO, "bad matrix row")
    // zero-norm inverse gives one all-zero result
    `QAU_ASSERT_NOW(a_zero_inv, res_valid && res_data.status == STAT_ZERO, res_data.last && res_data.res_x == 32'sd0 && res_data.res_y == 32'sd0 && res_data.res_z == 32'sd0 && res_data.res_w == 32'sd0, "bad zero-norm result")

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
